/* sv/rts_pkg.sv */
package rts_pkg;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_AFTER_SEC,
    PH_FRAC_START,
    PH_FRAC,
    PH_OFFSET,
    PH_END
  } phase_t;

  typedef struct packed {
    logic        bad;
    phase_t      phase;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  frac;
    logic [1:0]  frac_cnt;
    logic [14:0] zone;
  } rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_S1,
    BK_S2,
    BK_S3,
    BK_S4,
    BK_DONE
  } bk_state_t;

  localparam int unsigned QDepth = 2;
  localparam logic signed [23:0] DayBias = 24'sd865565;
  localparam logic [26:0] MsPerDay = 27'd86400000;

  function automatic logic [8:0] div25(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd5243;
    return 9'(p[25-1:17]);
  endfunction

  function automatic logic [8:0] doy_base(input logic [3:0] mm);
    case (mm)
      4'd0: return 9'd0;
      4'd1: return 9'd31;
      4'd2: return 9'd61;
      4'd3: return 9'd92;
      4'd4: return 9'd122;
      4'd5: return 9'd153;
      4'd6: return 9'd184;
      4'd7: return 9'd214;
      4'd8: return 9'd245;
      4'd9: return 9'd275;
      4'd10: return 9'd306;
      4'd11: return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    case (m)
      7'd2: return leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

endpackage

/* sv/rts_front.sv */
module rts_front import rts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] char_code,
  input  logic       is_last,
  input  logic       full,
  output logic       in_stall,
  output logic       push,
  output rec_t       push_rec
);

  logic [4:0] pos, pos_next;
  rec_t       st, st_next;
  logic       acc;
  logic       isd;
  logic [3:0] d;
  logic       zs_end, zs_off, zs_bad;
  logic [6:0] t;

  assign in_stall = full;
  assign acc = in_valid && !in_stall;
  assign push = acc && is_last;
  assign isd = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign d = char_code[3:0];
  assign zs_end = (char_code == "Z") || (char_code == "z");
  assign zs_off = (char_code == "+") || (char_code == "-");
  assign zs_bad = !zs_end && !zs_off;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] dd);
    return 7'((a << 3) + (a << 1) + 7'(dd));
  endfunction

  always_comb begin
    st_next = st;
    pos_next = pos;
    t = '0;
    if (!st.bad) begin
      case (st.phase)
        PH_FIXED: begin
          if (pos == 5'd4 || pos == 5'd7) begin
            if (char_code != "-") st_next.bad = 1'b1;
          end else if (pos == 5'd10) begin
            if (char_code != "T" && char_code != "t") st_next.bad = 1'b1;
          end else if (pos == 5'd13 || pos == 5'd16) begin
            if (char_code != ":") st_next.bad = 1'b1;
          end else if (!isd) begin
            st_next.bad = 1'b1;
          end else if (pos < 5'd4) begin
            st_next.year = 14'((st.year << 3) + (st.year << 1) + 14'(d));
          end else if (pos < 5'd7) begin
            st_next.month = acc2(st.month, d);
          end else if (pos < 5'd10) begin
            st_next.day = acc2(st.day, d);
          end else if (pos < 5'd13) begin
            st_next.hour = acc2(st.hour, d);
          end else if (pos < 5'd16) begin
            st_next.minute = acc2(st.minute, d);
          end else begin
            st_next.second = acc2(st.second, d);
          end
          pos_next = pos + 5'd1;
          if (pos >= 5'd18) st_next.phase = PH_AFTER_SEC;
        end
        PH_AFTER_SEC, PH_FRAC_START, PH_FRAC: begin
          if (st.phase == PH_AFTER_SEC && char_code == ".") begin
            st_next.phase = PH_FRAC_START;
          end else if (st.phase != PH_AFTER_SEC && isd) begin
            if (st.frac_cnt < 2'd3) begin
              st_next.frac = 10'((st.frac << 3) + (st.frac << 1) + 10'(d));
              st_next.frac_cnt = st.frac_cnt + 2'd1;
            end
            st_next.phase = PH_FRAC;
          end else if (st.phase == PH_FRAC_START) begin
            st_next.bad = 1'b1;
          end else if (zs_end) begin
            st_next.phase = PH_END;
          end else if (zs_off) begin
            st_next.zone = {char_code == "-", 14'd0};
            pos_next = '0;
            st_next.phase = PH_OFFSET;
          end else if (zs_bad) begin
            st_next.bad = 1'b1;
          end
        end
        PH_OFFSET: begin
          if (pos == 5'd2) begin
            if (char_code != ":") st_next.bad = 1'b1;
          end else if (!isd) begin
            st_next.bad = 1'b1;
          end else if (pos < 5'd2) begin
            t = acc2(st.zone[13:7], d);
            st_next.zone[13:7] = t;
          end else begin
            t = acc2(st.zone[6:0], d);
            st_next.zone[6:0] = t;
          end
          pos_next = pos + 5'd1;
          if (pos >= 5'd4) st_next.phase = PH_END;
        end
        default: begin
          st_next.bad = 1'b1;
        end
      endcase
    end
  end

  assign push_rec = st_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos <= '0;
      st <= '{bad: 1'b0, phase: PH_FIXED, default: '0};
    end else if (acc) begin
      pos <= pos_next;
      st <= st_next;
    end
  end

endmodule

/* sv/rts_queue.sv */
module rts_queue import rts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output rec_t head
);

  rec_t       mem [QDepth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(QDepth));
  assign nonempty = (count != 2'd0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* sv/rts_back.sv */
module rts_back import rts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  rec_t               head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic signed [48:0] unix_ms
);

  bk_state_t state, state_next;
  rec_t      r;
  logic [13:0] yy;
  logic [8:0]  q_y100, q_a, q_b, doy;
  logic [16:0] tod_s;
  logic [10:0] off_min;
  logic        ok_r;
  logic signed [23:0] days;
  logic [26:0] tod_ms, off_ms;
  logic signed [48:0] prod;
  logic        load_out;

  logic        early_m;
  logic [13:0] yy_c;
  logic        leap_c;
  logic [9:0]  frac_c;
  logic        ok_c;

  assign early_m = (r.month <= 7'd2);
  assign yy_c = 14'(r.year + 14'd400 - 14'(early_m));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (nonempty) state_next = BK_S1;
      BK_S1: state_next = BK_S2;
      BK_S2: state_next = BK_S3;
      BK_S3: state_next = BK_S4;
      BK_S4: state_next = BK_DONE;
      BK_DONE: if (!out_valid || !out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: pop = nonempty;
      BK_DONE: load_out = !out_valid || !out_stall;
      default: begin
        pop = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    leap_c = (r.year[1:0] == 2'b00) &&
             ((r.year != 14'(q_y100 * 7'd100)) || (q_y100[1:0] == 2'b00));
    case (r.frac_cnt)
      2'd0: frac_c = 10'd0;
      2'd1: frac_c = 10'(r.frac * 7'd100);
      2'd2: frac_c = 10'(r.frac * 4'd10);
      default: frac_c = r.frac;
    endcase
    ok_c = !r.bad && (r.phase == PH_END) && r.hour <= 7'd23 && r.minute <= 7'd59 &&
           r.second <= 7'd59 && r.zone[13:7] <= 7'd23 && r.zone[6:0] <= 7'd59 &&
           r.month >= 7'd1 && r.month <= 7'd12 && r.day >= 7'd1 &&
           r.day <= 7'(month_len(r.month, leap_c));
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (nonempty) r <= head;
      BK_S1: begin
        yy <= yy_c;
        q_y100 <= div25(12'(r.year >> 2));
        q_a <= div25(12'(yy_c >> 2));
        q_b <= div25(12'(yy_c >> 4));
        doy <= 9'(doy_base(early_m ? 4'(r.month + 7'd9) : 4'(r.month - 7'd3))
                  + 9'(r.day) - 9'd1);
        tod_s <= 17'((17'(r.hour) * 17'd60 + 17'(r.minute)) * 17'd60 + 17'(r.second));
        off_min <= 11'(11'(r.zone[13:7]) * 11'd60 + 11'(r.zone[6:0]));
      end
      BK_S2: begin
        ok_r <= ok_c;
        days <= 24'(signed'({10'd0, yy}) * 24'sd365) + 24'(yy >> 2)
                - 24'(q_a) + 24'(q_b) + 24'(doy) - DayBias;
        tod_ms <= 27'(27'(tod_s) * 27'd1000 + 27'(frac_c));
        off_ms <= 27'(27'(off_min) * 27'd60000);
      end
      BK_S3: begin
        prod <= 49'(49'(days) * signed'({22'd0, MsPerDay}));
      end
      BK_S4: begin
        if (r.zone[14]) prod <= prod + 49'(tod_ms) + 49'(off_ms);
        else prod <= prod + 49'(tod_ms) - 49'(off_ms);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok <= ok_r;
      unix_ms <= ok_r ? prod : '0;
    end
  end

endmodule

/* sv/rfc3339_timestamp_to_unix_ms.sv */
// Characters are taken one per cycle while the queue is not full; the final character of a string
// pushes a parsed record into a two-entry queue.
// A record then passes the converter states S1 to S4 and DONE before the output register.
// The converter takes a new record only once the last result is loaded to the output.
// Synchronous active-high reset clears the parser, queue and output valid.
module rfc3339_timestamp_to_unix_ms import rts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic signed [48:0] unix_ms
);

  logic push, pop, full, nonempty;
  rec_t push_rec, head;

  rts_front u_front (
    .clk, .rst, .in_valid, .char_code, .is_last, .full,
    .in_stall, .push, .push_rec
  );

  rts_queue u_queue (
    .clk, .rst, .push, .push_rec, .pop, .full, .nonempty, .head
  );

  rts_back u_back (
    .clk, .rst, .nonempty, .head, .pop, .out_valid, .out_stall, .ok, .unix_ms
  );

endmodule

/* sv/rts_checker.sv */
module rts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               ok,
  input logic signed [48:0] unix_ms
);

  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> unix_ms == 49'sd0) else $error("invalid result not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(unix_ms) && $stable(ok))
    else $error("stalled transfer changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> unix_ms >= -49'sd62167305540000 &&
    unix_ms <= 49'sd253402387139999) else $error("result out of range");

endmodule

bind rfc3339_timestamp_to_unix_ms rts_checker u_rts_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .ok, .unix_ms
);

/* dv/rfc3339_timestamp_to_unix_ms_tb.sv */
`timescale 1ns / 100ps

module rfc3339_timestamp_to_unix_ms_tb;
  import rts_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         char_code;
  logic               is_last;
  logic               out_valid;
  logic               out_stall;
  logic               ok;
  logic signed [48:0] unix_ms;

  typedef struct {
    logic               ok;
    logic signed [48:0] ms;
  } stamp_t;

  stamp_t pending_stamps[$];
  int     error_count;
  int     stamps_checked;
  int     stamps_valid;
  int     chars_sent;
  bit     quiet_sender;

  logic [4:0]  pos_q;
  phase_t      phase_q;
  logic        bad_q;
  logic [13:0] year_q;
  logic [6:0]  month_q;
  logic [6:0]  day_q;
  logic [6:0]  hour_q;
  logic [6:0]  minute_q;
  logic [6:0]  second_q;
  logic [9:0]  frac_q;
  logic [1:0]  frac_cnt_q;
  logic [14:0] zone_q;

  rfc3339_timestamp_to_unix_ms DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .unix_ms   (unix_ms)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic clear_parser();
    pos_q = '0;
    phase_q = PH_FIXED;
    bad_q = 1'b0;
    year_q = '0;
    month_q = '0;
    day_q = '0;
    hour_q = '0;
    minute_q = '0;
    second_q = '0;
    frac_q = '0;
    frac_cnt_q = '0;
    zone_q = '0;
  endtask

  function automatic logic [6:0] push_digit(logic [6:0] acc, int d);
    return 7'(int'(acc) * 10 + d);
  endfunction

  function automatic bit is_leap(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_in_month(longint y, int m);
    int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && is_leap(y)) return 29;
    return lens[m - 1];
  endfunction

  function automatic longint days_since_epoch(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic open_zone(logic [7:0] c);
    if (c == "Z" || c == "z") begin
      phase_q = PH_END;
    end else if (c == "+" || c == "-") begin
      zone_q = (c == "-") ? 15'h4000 : 15'h0;
      pos_q = '0;
      phase_q = PH_OFFSET;
    end else begin
      bad_q = 1'b1;
    end
  endtask

  task automatic parse_char(logic [7:0] c);
    bit isd;
    int d;
    int p;
    isd = (c >= "0" && c <= "9");
    d = isd ? int'(c) - 48 : 0;
    p = pos_q;
    case (phase_q)
      PH_FIXED: begin
        if (p == 4 || p == 7) begin
          if (c != "-") bad_q = 1'b1;
        end else if (p == 10) begin
          if (c != "T" && c != "t") bad_q = 1'b1;
        end else if (p == 13 || p == 16) begin
          if (c != ":") bad_q = 1'b1;
        end else if (!isd) begin
          bad_q = 1'b1;
        end else if (p < 4) begin
          year_q = 14'(int'(year_q) * 10 + d);
        end else if (p < 7) begin
          month_q = push_digit(month_q, d);
        end else if (p < 10) begin
          day_q = push_digit(day_q, d);
        end else if (p < 13) begin
          hour_q = push_digit(hour_q, d);
        end else if (p < 16) begin
          minute_q = push_digit(minute_q, d);
        end else begin
          second_q = push_digit(second_q, d);
        end
        pos_q = 5'(p + 1);
        if (p >= 18) phase_q = PH_AFTER_SEC;
      end
      PH_AFTER_SEC: begin
        if (c == ".") phase_q = PH_FRAC_START;
        else open_zone(c);
      end
      PH_FRAC_START, PH_FRAC: begin
        if (isd) begin
          if (frac_cnt_q < 3) begin
            frac_q = 10'(int'(frac_q) * 10 + d);
            frac_cnt_q = frac_cnt_q + 1;
          end
          phase_q = PH_FRAC;
        end else if (phase_q == PH_FRAC_START) begin
          bad_q = 1'b1;
        end else begin
          open_zone(c);
        end
      end
      PH_OFFSET: begin
        if (p == 2) begin
          if (c != ":") bad_q = 1'b1;
        end else if (!isd) begin
          bad_q = 1'b1;
        end else if (p < 2) begin
          zone_q[13:7] = push_digit(zone_q[13:7], d);
        end else begin
          zone_q[6:0] = push_digit(zone_q[6:0], d);
        end
        pos_q = 5'(p + 1);
        if (p >= 4) phase_q = PH_END;
      end
      default: bad_q = 1'b1;
    endcase
  endtask

  task automatic predict_char(logic [7:0] c, logic last);
    stamp_t s;
    longint y, frac, off, v;
    if (!bad_q) parse_char(c);
    if (last) begin
      y = year_q;
      s.ok = !bad_q && phase_q == PH_END && hour_q <= 23 && minute_q <= 59 &&
             second_q <= 59 && zone_q[13:7] <= 23 && zone_q[6:0] <= 59 &&
             month_q >= 1 && month_q <= 12 && day_q >= 1 &&
             day_q <= days_in_month(y, month_q);
      s.ms = '0;
      if (s.ok) begin
        frac = frac_q;
        for (int n = frac_cnt_q; n < 3; n++) frac = frac * 10;
        off = longint'(zone_q[13:7]) * 60 + zone_q[6:0];
        if (zone_q[14]) off = -off;
        v = days_since_epoch(y, month_q, day_q) * 86400000 +
            ((longint'(hour_q) * 60 + minute_q) * 60 + second_q) * 1000 +
            frac - off * 60000;
        s.ms = 49'(v);
      end
      pending_stamps.insert(pending_stamps.size(), s);
      clear_parser();
    end
  endtask

  task automatic report(string what);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_stamps.size() != 0) @(negedge clk);
  endtask

  function automatic string two_dig(int v);
    return $sformatf("%02d", v);
  endfunction

  function automatic string random_stamp();
    string s;
    int y, m, d, fl, pick;
    y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom_range(1900, 2100);
    if ($urandom_range(0, 5) == 0) y = 400 * $urandom_range(0, 24);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, days_in_month(y, m));
    if ($urandom_range(0, 9) == 0) d = days_in_month(y, m) + 1;
    if ($urandom_range(0, 15) == 0) m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
    s = $sformatf("%04d-%s-%s%s%s:%s:%s", y, two_dig(m), two_dig(d),
                  $urandom_range(0, 1) ? "T" : "t",
                  two_dig($urandom_range(0, 15) == 0 ? $urandom_range(24, 99) :
                          $urandom_range(0, 23)),
                  two_dig($urandom_range(0, 15) == 0 ? $urandom_range(60, 99) :
                          $urandom_range(0, 59)),
                  two_dig($urandom_range(0, 15) == 0 ? $urandom_range(60, 99) :
                          $urandom_range(0, 59)));
    if ($urandom_range(0, 1)) begin
      fl = $urandom_range(1, 6);
      s = {s, "."};
      for (int i = 0; i < fl; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    pick = $urandom_range(0, 3);
    if (pick == 0) s = {s, "Z"};
    else if (pick == 1) s = {s, "z"};
    else s = {s, $urandom_range(0, 1) ? "+" : "-",
              two_dig($urandom_range(0, 12) == 0 ? $urandom_range(24, 99) :
                      $urandom_range(0, 23)), ":",
              two_dig($urandom_range(0, 12) == 0 ? $urandom_range(60, 99) :
                      $urandom_range(0, 59))};
    return s;
  endfunction

  task automatic send_damaged(string s);
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) s = s.substr(0, $urandom_range(0, s.len() - 2));
    else if (k == 1) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
    else if (k == 2) s = {s, "Z"};
    else begin
      for (int i = 0; i < s.len(); i++) s[i] = 8'($urandom_range(0, 255));
    end
    send_text(s);
  endtask

  always @(posedge clk) begin
    stamp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stamps.size() == 0) begin
        report("result transfer with no string outstanding");
      end else begin
        want = pending_stamps.pop_front();
        stamps_checked++;
        if (want.ok) stamps_valid++;
        if (ok !== want.ok)
          report($sformatf("ok: got %b, expected %b", ok, want.ok));
        if (unix_ms !== want.ms)
          report($sformatf("unix_ms: got %0d, expected %0d", unix_ms, want.ms));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 7) != 0);
    else if ($urandom_range(0, 1)) out_stall <= 1'b0;
  end

  task automatic test_valid_extremes();
    send_text("0000-01-01T00:00:00Z");
    send_text("9999-12-31T23:59:59.999z");
    send_text("1970-01-01t00:00:00.5+00:00");
    send_text("2000-02-29T12:30:45.12-23:59");
    send_text("1900-02-29T00:00:00Z");
    send_text("2024-02-29T23:59:59.123456+23:59");
    send_text("0000-01-01T00:00:00+23:59");
    send_text("9999-12-31T23:59:59.999-23:59");
  endtask

  task automatic test_malformed();
    send_text("2020-13-01T00:00:00Z");
    send_text("2020-04-31T24:00:00Z");
    send_text("2020-01-01T00:60:60Z");
    send_text("2020-01-01T00:00:00+24:60");
    send_text("2020-01-01T00:00:00.Z");
    send_text("2020-01-01T00:00:00ZZ");
    send_text("2020-01-01T00:00");
    send_text("2020-01-01X00:00:00Z");
    send_text("2020/01-01T00:00:00+01:0");
    send_text("2020-00-00T00:00:00+01:00:");
    send_text(string'({8'hff, 8'h80, "020-01-01T00:00:00Z"}));
    send_char(8'h7f, 1'b1);
  endtask

  task automatic test_random_strings();
    while (chars_sent < 1950) begin
      if ($urandom_range(0, 4) == 0) send_damaged(random_stamp());
      else send_text(random_stamp());
      if ($urandom_range(0, 60) == 0) begin
        quiet_sender = ~quiet_sender;
      end
    end
    quiet_sender = 1'b0;
  endtask

  task automatic test_pause_drain();
    send_text("2038-01-19T03:14:07.99+05:30");
    wait_drained();
    send_text("1969-12-31T23:59:59.999Z");
  endtask

  initial begin
    error_count = 0;
    stamps_checked = 0;
    stamps_valid = 0;
    chars_sent = 0;
    quiet_sender = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    is_last = 1'b0;
    out_stall = 1'b0;
    clear_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_valid_extremes();
    test_malformed();
    test_pause_drain();
    test_random_strings();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d characters; checked %0d timestamps, %0d of them valid.",
             chars_sent, stamps_checked, stamps_valid);
    if (error_count == 0) begin
      $display("rfc3339_timestamp_to_unix_ms_tb: done, clean");
    end else begin
      $display("rfc3339_timestamp_to_unix_ms_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout waiting for the run to complete.");
    $display("rfc3339_timestamp_to_unix_ms_tb: done, errors");
    $finish;
  end

endmodule
